@@ sv/ccc_pkg.sv @@
// Package for the compressor cycle controller: phase codes, register indexes,
// configuration and controller state types. No dependencies.
package ccc_pkg;

	// Controller phase, also the value of the phase result field
	typedef enum logic [2:0] {
		PH_WAIT     = 3'd0,
		PH_STARTING = 3'd1,
		PH_RUNNING  = 3'd2,
		PH_STOPPING = 3'd3,
		PH_HOLD     = 3'd4
	} phase_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_THR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_IDLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP      = 3'd4;

	localparam int unsigned TEMP_W = 12;
	localparam int unsigned SEC_W  = 16;
	localparam int unsigned DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic signed [TEMP_W-1:0] START_THR_RST = -12'sd256;
	localparam logic signed [TEMP_W-1:0] STOP_THR_RST  = -12'sd352;
	localparam logic [SEC_W-1:0]         MAX_RUN_RST   = 16'd1200;
	localparam logic [SEC_W-1:0]         MIN_IDLE_RST  = 16'd600;
	localparam logic [SEC_W-1:0]         WRAP_RST      = 16'd43200;

	typedef struct packed {
		logic signed [TEMP_W-1:0] start_thr;
		logic signed [TEMP_W-1:0] stop_thr;
		logic [SEC_W-1:0]         max_run;
		logic [SEC_W-1:0]         min_idle;
		logic [SEC_W-1:0]         wrap;
	} cfg_regs_t;

	// Controller state carried from one request to the next
	typedef struct packed {
		phase_t           phase;
		logic [SEC_W-1:0] seconds;
		logic [SEC_W-1:0] stamp;
		logic [SEC_W-1:0] run_dur;
		logic [SEC_W-1:0] idle_dur;
		logic             relay;
	} ctrl_state_t;

endpackage

@@ sv/ccc_cfg.sv @@
// Configuration register file of the compressor cycle controller.
// Depends on ccc_pkg.
module ccc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ccc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccc_pkg::DATA_W-1:0]    cfg_data,
	output ccc_pkg::cfg_regs_t           regs
);

	ccc_pkg::cfg_regs_t regs_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Register write; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_thr <= ccc_pkg::START_THR_RST;
			regs_q.stop_thr  <= ccc_pkg::STOP_THR_RST;
			regs_q.max_run   <= ccc_pkg::MAX_RUN_RST;
			regs_q.min_idle  <= ccc_pkg::MIN_IDLE_RST;
			regs_q.wrap      <= ccc_pkg::WRAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ccc_pkg::REG_START_THR: regs_q.start_thr <= cfg_data[ccc_pkg::TEMP_W-1:0];
				ccc_pkg::REG_STOP_THR:  regs_q.stop_thr  <= cfg_data[ccc_pkg::TEMP_W-1:0];
				ccc_pkg::REG_MAX_RUN:   regs_q.max_run   <= cfg_data[ccc_pkg::SEC_W-1:0];
				ccc_pkg::REG_MIN_IDLE:  regs_q.min_idle  <= cfg_data[ccc_pkg::SEC_W-1:0];
				ccc_pkg::REG_WRAP:      regs_q.wrap      <= cfg_data[ccc_pkg::SEC_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ sv/ccc_step.sv @@
// One control pass of the compressor cycle controller: next phase and the
// updated counters, stamps and relay level. Pure logic; depends on ccc_pkg.
module ccc_step (
	input  ccc_pkg::cfg_regs_t             regs,
	input  ccc_pkg::ctrl_state_t           cur,
	input  logic                           tick,
	input  logic signed [ccc_pkg::TEMP_W-1:0] temp,
	input  logic                           good,
	output ccc_pkg::ctrl_state_t           nxt,
	output logic                           pulse
);

	logic [ccc_pkg::SEC_W-1:0] cnt;
	logic [ccc_pkg::SEC_W-1:0] elapsed;
	logic                      start_req;
	logic                      stop_req;
	ccc_pkg::phase_t           phase_n;

	function automatic logic [ccc_pkg::SEC_W-1:0] cnt_inc(input logic [ccc_pkg::SEC_W-1:0] v);
		return v + 1'b1;
	endfunction

	// Seconds counter advances first, elapsed time is modulo 2^16
	assign cnt       = tick ? cnt_inc(cur.seconds) : cur.seconds;
	assign elapsed   = cnt - cur.stamp;
	assign start_req = !good || (temp > regs.start_thr);
	assign stop_req  = (elapsed >= regs.max_run) || (good && (temp < regs.stop_thr));

	// Next phase
	always_comb begin
		unique case (cur.phase)
			ccc_pkg::PH_WAIT:     phase_n = start_req ? ccc_pkg::PH_STARTING : ccc_pkg::PH_WAIT;
			ccc_pkg::PH_STARTING: phase_n = ccc_pkg::PH_RUNNING;
			ccc_pkg::PH_RUNNING:  phase_n = stop_req ? ccc_pkg::PH_STOPPING : ccc_pkg::PH_RUNNING;
			ccc_pkg::PH_STOPPING: phase_n = ccc_pkg::PH_HOLD;
			ccc_pkg::PH_HOLD:     phase_n = (elapsed >= regs.min_idle) ? ccc_pkg::PH_WAIT
			                                                           : ccc_pkg::PH_HOLD;
			default:              phase_n = ccc_pkg::PH_WAIT;
		endcase
	end

	// Counters, stamps, relay and start pulse
	always_comb begin
		nxt         = cur;
		nxt.phase   = phase_n;
		nxt.seconds = cnt;
		pulse       = 1'b0;
		unique case (cur.phase)
			ccc_pkg::PH_WAIT: begin
				if (cnt >= regs.wrap)
					nxt.seconds = '0;
			end
			ccc_pkg::PH_STARTING: begin
				nxt.idle_dur = elapsed;
				nxt.stamp    = cnt;
				nxt.relay    = 1'b1;
				pulse        = 1'b1;
			end
			ccc_pkg::PH_STOPPING: begin
				nxt.run_dur = elapsed;
				nxt.stamp   = cnt;
				nxt.relay   = 1'b0;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/compressor_cycle_controller.sv @@
// Top level of the freezer compressor cycle controller: input register,
// controller state, result register. Depends on ccc_pkg, ccc_cfg, ccc_step.
//
//  channel | direction | handshake            | payload
//  in      | into      | in_valid / in_stall  | second_tick, freezer_temp, sensor_good
//  out     | out of    | out_valid / out_stall| compressor_run, start_pulse, phase,
//          |           |                      | last_run_seconds, last_idle_seconds
//  cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request is captured in the input register, then one pass of logic updates
// the controller state and loads the result register. One request per cycle is
// sustained; in_stall rises only when the input register is full and the
// result register is held by out_stall. arst_n returns the phase to wait,
// clears counters and relay, and loads the register reset values.
module compressor_cycle_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              second_tick,
	input  logic signed [11:0]                freezer_temp,
	input  logic                              sensor_good,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              compressor_run,
	output logic                              start_pulse,
	output logic [2:0]                        phase,
	output logic [15:0]                       last_run_seconds,
	output logic [15:0]                       last_idle_seconds,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ccc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ccc_pkg::DATA_W-1:0]        cfg_data
);

	ccc_pkg::cfg_regs_t   regs;
	ccc_pkg::ctrl_state_t state_q;
	ccc_pkg::ctrl_state_t state_n;
	logic                 pulse_n;

	logic                              valid_s1;
	logic                              tick_s1;
	logic signed [ccc_pkg::TEMP_W-1:0] temp_s1;
	logic                              good_s1;
	logic                              adv_s1;
	logic                              in_take;

	logic                              out_valid_q;
	logic                              pulse_q;

	ccc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	ccc_step u_step (
		.regs  (regs),
		.cur   (state_q),
		.tick  (tick_s1),
		.temp  (temp_s1),
		.good  (good_s1),
		.nxt   (state_n),
		.pulse (pulse_n)
	);

	// Flow control
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1 <= second_tick;
			temp_s1 <= freezer_temp;
			good_s1 <= sensor_good;
		end
	end

	// Controller state, advanced once per pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= ccc_pkg::PH_WAIT;
			state_q.seconds  <= '0;
			state_q.stamp    <= '0;
			state_q.run_dur  <= '0;
			state_q.idle_dur <= '0;
			state_q.relay    <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_n;
		end
	end

	// Result register: the state fields double as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			pulse_q <= pulse_n;
	end

	assign out_valid         = out_valid_q;
	assign compressor_run    = state_q.relay;
	assign start_pulse       = pulse_q;
	assign phase             = state_q.phase;
	assign last_run_seconds  = state_q.run_dur;
	assign last_idle_seconds = state_q.idle_dur;

endmodule

@@ bench/compressor_cycle_controller_tb.sv @@
`timescale 1ns / 100ps
// Testbench for compressor_cycle_controller: directed and random control passes,
// each result checked against a behavioural model of the phase sequencer.
// Depends on ccc_pkg and the controller RTL.
module testbench;

	// One expected result, field for field
	typedef struct packed {
		logic                      relay;
		logic                      pulse;
		logic [2:0]                phase;
		logic [ccc_pkg::SEC_W-1:0] run_secs;
		logic [ccc_pkg::SEC_W-1:0] idle_secs;
	} pass_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic                              second_tick = 1'b0;
	logic signed [ccc_pkg::TEMP_W-1:0] freezer_temp = '0;
	logic                              sensor_good = 1'b0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic                              compressor_run;
	logic                              start_pulse;
	logic [2:0]                        phase;
	logic [15:0]                       last_run_seconds;
	logic [15:0]                       last_idle_seconds;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [ccc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [ccc_pkg::DATA_W-1:0]        cfg_data = '0;

	// Model state and register copy
	ccc_pkg::cfg_regs_t   cfg;
	ccc_pkg::ctrl_state_t ctl;
	pass_result_t         expected_results[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;

	compressor_cycle_controller u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.second_tick       (second_tick),
		.freezer_temp      (freezer_temp),
		.sensor_good       (sensor_good),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.compressor_run    (compressor_run),
		.start_pulse       (start_pulse),
		.phase             (phase),
		.last_run_seconds  (last_run_seconds),
		.last_idle_seconds (last_idle_seconds),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random back-pressure on the result channel
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// One control pass of the sequencer; updates ctl and returns the result
	function automatic pass_result_t advance_controller(input logic tick,
			input logic signed [ccc_pkg::TEMP_W-1:0] temp, input logic good);
		logic [ccc_pkg::SEC_W-1:0] elapsed;
		logic                      pulse;
		pass_result_t              res;
		pulse = 1'b0;
		if (tick)
			ctl.seconds = ctl.seconds + 1'b1;
		// modulo-65536 difference, so limits survive counter rollover
		elapsed = ctl.seconds - ctl.stamp;
		case (ctl.phase)
			ccc_pkg::PH_WAIT: begin
				if (ctl.seconds >= cfg.wrap)
					ctl.seconds = '0;
				if (!good || $signed(temp) > $signed(cfg.start_thr))
					ctl.phase = ccc_pkg::PH_STARTING;
			end
			ccc_pkg::PH_STARTING: begin
				ctl.idle_dur = elapsed;
				ctl.stamp    = ctl.seconds;
				ctl.relay    = 1'b1;
				pulse        = 1'b1;
				ctl.phase    = ccc_pkg::PH_RUNNING;
			end
			ccc_pkg::PH_RUNNING: begin
				if (elapsed >= cfg.max_run)
					ctl.phase = ccc_pkg::PH_STOPPING;
				// a bad reading never stops the compressor on temperature
				if (good && $signed(temp) < $signed(cfg.stop_thr))
					ctl.phase = ccc_pkg::PH_STOPPING;
			end
			ccc_pkg::PH_STOPPING: begin
				ctl.run_dur = elapsed;
				ctl.stamp   = ctl.seconds;
				ctl.relay   = 1'b0;
				ctl.phase   = ccc_pkg::PH_HOLD;
			end
			ccc_pkg::PH_HOLD: begin
				if (elapsed >= cfg.min_idle)
					ctl.phase = ccc_pkg::PH_WAIT;
			end
			default: begin
				ctl.phase = ccc_pkg::PH_WAIT;
			end
		endcase
		res.relay     = ctl.relay;
		res.pulse     = pulse;
		res.phase     = ctl.phase;
		res.run_secs  = ctl.run_dur;
		res.idle_secs = ctl.idle_dur;
		return res;
	endfunction

	// Register write as seen by the block; spare indexes are dropped
	function automatic void apply_register(input logic [ccc_pkg::CFG_IDX_W-1:0] idx,
			input logic [ccc_pkg::DATA_W-1:0] data);
		case (idx)
			ccc_pkg::REG_START_THR: cfg.start_thr = data[ccc_pkg::TEMP_W-1:0];
			ccc_pkg::REG_STOP_THR:  cfg.stop_thr  = data[ccc_pkg::TEMP_W-1:0];
			ccc_pkg::REG_MAX_RUN:   cfg.max_run   = data;
			ccc_pkg::REG_MIN_IDLE:  cfg.min_idle  = data;
			ccc_pkg::REG_WRAP:      cfg.wrap      = data;
			default: ;
		endcase
	endfunction

	task automatic reset_model();
		cfg.start_thr = ccc_pkg::START_THR_RST;
		cfg.stop_thr  = ccc_pkg::STOP_THR_RST;
		cfg.max_run   = ccc_pkg::MAX_RUN_RST;
		cfg.min_idle  = ccc_pkg::MIN_IDLE_RST;
		cfg.wrap      = ccc_pkg::WRAP_RST;
		ctl.phase     = ccc_pkg::PH_WAIT;
		ctl.seconds   = '0;
		ctl.stamp     = '0;
		ctl.run_dur   = '0;
		ctl.idle_dur  = '0;
		ctl.relay     = 1'b0;
	endtask

	// Send one pass request; valid stays high after acceptance
	task automatic send_pass(input logic tick,
			input logic signed [ccc_pkg::TEMP_W-1:0] temp, input logic good);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		second_tick  <= tick;
		freezer_temp <= temp;
		sensor_good  <= good;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(advance_controller(tick, temp, good));
	endtask

	// Stop sending and wait for every outstanding result
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	task automatic write_reg(input logic [ccc_pkg::CFG_IDX_W-1:0] idx,
			input logic [ccc_pkg::DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(idx, data);
	endtask

	// Full register load while idle, plus one write to a spare index
	task automatic configure(input int start_thr, input int stop_thr,
			input int unsigned max_run, input int unsigned min_idle,
			input int unsigned wrap);
		logic [ccc_pkg::CFG_IDX_W-1:0] spare_idx;
		wait_until_drained();
		// upper nibble of the threshold data is don't-care
		write_reg(ccc_pkg::REG_START_THR, {4'($urandom), 12'(start_thr)});
		write_reg(ccc_pkg::REG_STOP_THR, {4'($urandom), 12'(stop_thr)});
		write_reg(ccc_pkg::REG_MAX_RUN, 16'(max_run));
		write_reg(ccc_pkg::REG_MIN_IDLE, 16'(min_idle));
		write_reg(ccc_pkg::REG_WRAP, 16'(wrap));
		spare_idx = ccc_pkg::REG_WRAP + 3'd1 + 3'($urandom_range(2));
		write_reg(spare_idx, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Temperatures mostly around the thresholds, some anywhere
	task automatic send_random_pass();
		int          s0;
		int          s1;
		int          lo;
		int          hi;
		int          t;
		int unsigned pick;
		s0 = $signed(cfg.start_thr);
		s1 = $signed(cfg.stop_thr);
		lo = ((s0 < s1) ? s0 : s1) - 24;
		hi = ((s0 > s1) ? s0 : s1) + 24;
		if (lo < -2048)
			lo = -2048;
		if (hi > 2047)
			hi = 2047;
		pick = $urandom_range(99);
		if (pick < 60)
			t = lo + int'($urandom_range(hi - lo));
		else if (pick < 78)
			t = (pick[0] ? s0 : s1) + int'($urandom_range(2)) - 1;
		else
			t = $signed(12'($urandom));
		send_pass($urandom_range(99) < 60, 12'(t), $urandom_range(99) < 88);
	endtask

	// Reset register values: start/stop threshold edges, one full cycle
	task automatic test_reset_defaults();
		send_pass(1'b0, -12'sd400, 1'b1);
		send_pass(1'b1, -12'sd256, 1'b1);
		send_pass(1'b1, -12'sd255, 1'b1);
		send_pass(1'b0, -12'sd1000, 1'b1);
		send_pass(1'b1, -12'sd352, 1'b1);
		send_pass(1'b0, -12'sd353, 1'b1);
		send_pass(1'b0, 12'sd0, 1'b1);
		send_pass(1'b1, 12'sd0, 1'b1);
	endtask

	// Temperature extremes, bad sensor start, bad sensor while running
	task automatic test_sensor_and_extremes();
		configure(2047, -2048, 3, 2, 10);
		repeat (3)
			send_pass(1'b1, 12'sd0, 1'b1);
		send_pass(1'b1, -12'sd2048, 1'b1);
		send_pass(1'b1, 12'sd2047, 1'b1);
		send_pass(1'b0, -12'sd880, 1'b1);
		send_pass(1'b0, 12'sd2000, 1'b1);
		send_pass(1'b0, 12'sd0, 1'b0);
		// cold and bad: only the run limit can end this run
		repeat (6)
			send_pass(1'b1, -12'sd2048, 1'b0);
	endtask

	// Zero run and idle limits, wrap of zero clears every wait pass
	task automatic test_zero_limits();
		configure(2047, -2048, 0, 0, 0);
		repeat (8)
			send_pass(1'b1, 12'sd0, 1'b0);
		repeat (3)
			send_pass(1'b1, 12'sd0, 1'b1);
	endtask

	// Random passes under one idling pattern, across three register settings
	task automatic test_random_traffic(input int unsigned idle_pct,
			input int unsigned stall_pct, input int unsigned n_items);
		int          thr_edges[4] = '{-2048, 2047, -880, 2000};
		int unsigned lim_edges[4] = '{0, 1, 1, 65535};
		int          st;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < 3; k++) begin
			case (k)
				0: begin
					st = -400 + int'($urandom_range(600));
					configure(st, st - int'($urandom_range(160)), $urandom_range(12),
						$urandom_range(12), $urandom_range(40));
				end
				1: begin
					configure(thr_edges[$urandom_range(3)], thr_edges[$urandom_range(3)],
						lim_edges[$urandom_range(3)], lim_edges[$urandom_range(3)],
						lim_edges[$urandom_range(3)]);
				end
				default: begin
					configure(int'($urandom_range(2880)) - 880,
						int'($urandom_range(2880)) - 880, $urandom_range(30),
						$urandom_range(30), $urandom_range(65535));
				end
			endcase
			repeat (n_items / 3)
				send_random_pass();
		end
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		pass_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no pending request");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (compressor_run !== want.relay) begin
					$error("compressor_run: expected %0d, got %0d", want.relay,
						compressor_run);
					fail_count++;
				end
				if (start_pulse !== want.pulse) begin
					$error("start_pulse: expected %0d, got %0d", want.pulse, start_pulse);
					fail_count++;
				end
				if (phase !== want.phase) begin
					$error("phase: expected %0d, got %0d", want.phase, phase);
					fail_count++;
				end
				if (last_run_seconds !== want.run_secs) begin
					$error("last_run_seconds: expected %0d, got %0d", want.run_secs,
						last_run_seconds);
					fail_count++;
				end
				if (last_idle_seconds !== want.idle_secs) begin
					$error("last_idle_seconds: expected %0d, got %0d", want.idle_secs,
						last_idle_seconds);
					fail_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin : run_tests
		int unsigned drain_cycles;
		reset_model();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_sensor_and_extremes();
		test_zero_limits();

		test_random_traffic(0, 0, 462);
		test_random_traffic(67, 0, 462);
		test_random_traffic(0, 67, 462);
		test_random_traffic(16, 16, 462);

		// drain, then watch for any stray result
		in_valid <= 1'b0;
		drain_cycles = 0;
		while (expected_results.size() != 0 && drain_cycles < 10000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (4)
			@(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("** compressor_cycle_controller: PASSED **");
		else
			$display("** compressor_cycle_controller: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#10ms;
		$display("** compressor_cycle_controller: FAILED **");
		$finish;
	end

endmodule
